>>> rtl/csp_pkg.sv
// Shared types, constants and character codes for the comment score parser.
package csp_pkg;

   localparam int unsigned TOKEN_BUFFER_DEFAULT = 64;
   localparam logic [14:0] CHECKMATE_RESET = 15'd32000;

   localparam logic [15:0] WHOLE_MAX = 16'd65535;
   localparam logic [13:0] MATE_MAX = 14'd16383;
   localparam logic [15:0] SCORE_MAX = 16'd32767;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_CLOSE = 8'h7D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_MATE_UPPER = 8'h4D;
   localparam logic [7:0] CHAR_MATE_LOWER = 8'h6D;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic               score_valid;
      logic signed [15:0] score;
   } rsp_item_type;

   typedef enum logic [1:0] {
      PHASE_SPACE   = 2'd0,
      PHASE_TOKEN   = 2'd1,
      PHASE_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      STEP_START    = 3'd0,
      STEP_SIGNED   = 3'd1,
      STEP_MATE     = 3'd2,
      STEP_MATE_END = 3'd3,
      STEP_WHOLE    = 3'd4,
      STEP_FRAC1    = 3'd5,
      STEP_FRAC2    = 3'd6,
      STEP_NUM_END  = 3'd7
   } step_type;

   typedef struct packed {
      step_type    step;
      logic        negative;
      logic [15:0] whole_part;
      logic [6:0]  fraction_part;
      logic [13:0] mate_count;
   } parse_state_type;

endpackage

>>> rtl/comment_score_parser.sv
// Top level of the comment score parser: input register, control register and handshakes.
//
//   channel  direction  ports                       moves
//   req      in         req_valid/ready, req_item   one comment byte or end of stream
//   rsp      out        rsp_valid/ready, rsp_item   one score item per closed comment
//   csr      in         csr_we, csr_wdata           checkmate value
//
// One item is taken per cycle, except while a closing item waits in the input register. A
// closing item's result is written to the result register as the item leaves that register.
// Only a closing item waits for a full result register; other items pass it.
// Reset is synchronous and returns the parser to leading whitespace, the checkmate
// value to 32000 and both registers to empty.
module comment_score_parser #(
   parameter int unsigned TOKEN_BUFFER = csp_pkg::TOKEN_BUFFER_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csp_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csp_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [14:0]           csr_wdata
);
   import csp_pkg::*;

   logic            in_valid_ff;
   req_item_type    in_item_ff;
   logic [14:0]     checkmate_ff;
   logic            is_close;
   logic            advance;
   logic            slot_free;
   parse_state_type parse_state;

   assign is_close = in_item_ff.end_of_stream || (in_item_ff.ch == CHAR_CLOSE);
   assign advance = in_valid_ff && (!is_close || slot_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         checkmate_ff <= CHECKMATE_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            checkmate_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   csp_token #(
      .TOKEN_BUFFER(TOKEN_BUFFER)
   ) u_token (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .parse_state (parse_state)
   );

   csp_score u_score (
      .clock           (clock),
      .reset           (reset),
      .close_fire      (advance && is_close),
      .parse_state     (parse_state),
      .checkmate_value (checkmate_ff),
      .rsp_ready       (rsp_ready),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_item        (rsp_item)
   );

endmodule

>>> rtl/csp_token.sv
// Token scanner: per-byte update of the phase, token length and digit accumulators.
module csp_token #(
   parameter int unsigned TOKEN_BUFFER = csp_pkg::TOKEN_BUFFER_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  csp_pkg::req_item_type    item,
   output csp_pkg::parse_state_type parse_state
);
   import csp_pkg::*;

   localparam int unsigned LEN_W = $clog2(TOKEN_BUFFER);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(TOKEN_BUFFER - 1);

   phase_type       phase_ff, phase_in;
   logic [LEN_W-1:0] length_ff, length_in;
   parse_state_type state_ff, state_in;

   logic        is_close;
   logic        is_space;
   logic        is_digit;
   logic        is_mate;
   logic [3:0]  digit;
   logic        feed;
   logic [19:0] whole_mac;
   logic [17:0] mate_mac;

   always_comb begin
      is_close = item.end_of_stream || (item.ch == CHAR_CLOSE);
      is_space = (item.ch == CHAR_SPACE) || (item.ch == CHAR_TAB) ||
                 (item.ch == CHAR_LF) || (item.ch == CHAR_CR);
      is_digit = item.ch inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]};
      is_mate = (item.ch == CHAR_MATE_UPPER) || (item.ch == CHAR_MATE_LOWER);
      digit = is_digit ? item.ch[3:0] : 4'd0;
      whole_mac = 20'(state_ff.whole_part) * 20'd10 + 20'(digit);
      mate_mac = 18'(state_ff.mate_count) * 18'd10 + 18'(digit);

      phase_in = phase_ff;
      length_in = length_ff;
      state_in = state_ff;
      feed = 1'b0;

      if (is_close) begin
         phase_in = PHASE_SPACE;
         length_in = '0;
         state_in = '{step: STEP_START, negative: 1'b0, whole_part: '0,
                      fraction_part: '0, mate_count: '0};
      end else begin
         case (phase_ff)
            PHASE_SPACE: begin
               if (item.ch == CHAR_SLASH) begin
                  phase_in = PHASE_DISCARD;
               end else if (!is_space) begin
                  feed = 1'b1;
               end
            end
            PHASE_TOKEN: begin
               if (is_space || (item.ch == CHAR_SLASH)) begin
                  phase_in = PHASE_DISCARD;
               end else begin
                  feed = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (feed) begin
         case (state_ff.step)
            STEP_START, STEP_SIGNED: begin
               if ((state_ff.step == STEP_START) && (item.ch == CHAR_PLUS)) begin
                  state_in.step = STEP_SIGNED;
               end else if ((state_ff.step == STEP_START) && (item.ch == CHAR_MINUS)) begin
                  state_in.negative = 1'b1;
                  state_in.step = STEP_SIGNED;
               end else if (is_mate) begin
                  state_in.step = STEP_MATE;
               end else if (is_digit) begin
                  state_in.whole_part = 16'(digit);
                  state_in.step = STEP_WHOLE;
               end else begin
                  state_in.step = STEP_MATE_END;
               end
            end
            STEP_MATE: begin
               if (is_digit) begin
                  state_in.mate_count = (mate_mac > 18'(MATE_MAX)) ? MATE_MAX : mate_mac[13:0];
               end else begin
                  state_in.step = STEP_MATE_END;
               end
            end
            STEP_WHOLE: begin
               if (is_digit) begin
                  state_in.whole_part =
                     (whole_mac > 20'(WHOLE_MAX)) ? WHOLE_MAX : whole_mac[15:0];
               end else if (item.ch == CHAR_DOT) begin
                  state_in.step = STEP_FRAC1;
               end else begin
                  state_in.step = STEP_NUM_END;
               end
            end
            STEP_FRAC1: begin
               if (is_digit) begin
                  state_in.fraction_part = 7'(digit) * 7'd10;
                  state_in.step = STEP_FRAC2;
               end else begin
                  state_in.step = STEP_NUM_END;
               end
            end
            STEP_FRAC2: begin
               if (is_digit) begin
                  state_in.fraction_part = state_ff.fraction_part + 7'(digit);
               end
               state_in.step = STEP_NUM_END;
            end
            default: begin
            end
         endcase
         length_in = length_ff + 1'b1;
         phase_in = (length_in >= LEN_LAST) ? PHASE_DISCARD : PHASE_TOKEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SPACE;
         length_ff <= '0;
         state_ff <= '{step: STEP_START, negative: 1'b0, whole_part: '0,
                       fraction_part: '0, mate_count: '0};
      end else if (advance) begin
         phase_ff <= phase_in;
         length_ff <= length_in;
         state_ff <= state_in;
      end
   end

   assign parse_state = state_ff;

endmodule

>>> rtl/csp_score.sv
// Score former: turns the parse state into a result item and holds it in the result register.
module csp_score (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     close_fire,
   input  csp_pkg::parse_state_type parse_state,
   input  logic [14:0]              checkmate_value,
   input  logic                     rsp_ready,
   output logic                     slot_free,
   output logic                     rsp_valid,
   output csp_pkg::rsp_item_type    rsp_item
);
   import csp_pkg::*;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   logic [22:0]        decimal_sum;
   logic [15:0]        decimal_score;
   logic signed [16:0] mate_score;
   logic signed [15:0] magnitude;
   logic               valid;

   always_comb begin
      decimal_sum = 23'(parse_state.whole_part) * 23'd100 + 23'(parse_state.fraction_part);
      decimal_score = (decimal_sum > 23'(SCORE_MAX)) ? SCORE_MAX : decimal_sum[15:0];
      mate_score = signed'({2'b00, checkmate_value}) -
                   signed'({2'b00, parse_state.mate_count, 1'b0}) + 17'sd1;

      case (parse_state.step)
         STEP_MATE, STEP_MATE_END: begin
            valid = (parse_state.mate_count != '0);
            magnitude = mate_score[15:0];
         end
         STEP_WHOLE, STEP_FRAC1, STEP_FRAC2, STEP_NUM_END: begin
            valid = 1'b1;
            magnitude = signed'(decimal_score);
         end
         default: begin
            valid = 1'b0;
            magnitude = '0;
         end
      endcase

      rsp_item_in.score_valid = valid;
      if (!valid) begin
         rsp_item_in.score = '0;
      end else if (parse_state.negative) begin
         rsp_item_in.score = -magnitude;
      end else begin
         rsp_item_in.score = magnitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (close_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

>>> tb/sv/tb_comment_score_parser.sv
// Self-checking testbench for comment_score_parser with a byte-level score predictor.
module tb_comment_score_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import csp_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 6;
   localparam int BYTES_PER_SEGMENT = 250;

   class comment_scorer;
      logic [14:0]  mate_base;
      phase_type    phase;
      step_type     step;
      logic         negative;
      int unsigned  token_len;
      logic [15:0]  whole_part;
      logic [6:0]   fraction_part;
      logic [13:0]  mate_count;
      rsp_item_type expected_scores[$];
      int unsigned  mismatches;
      int unsigned  closes;
      int unsigned  valid_scores;
      int unsigned  mate_scores;

      function new();
         mate_base = CHECKMATE_RESET;
         mismatches = 0;
         closes = 0;
         valid_scores = 0;
         mate_scores = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase = PHASE_SPACE;
         step = STEP_START;
         negative = 1'b0;
         token_len = 0;
         whole_part = '0;
         fraction_part = '0;
         mate_count = '0;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
      endfunction

      function void read_lead(logic [7:0] c);
         if (c == CHAR_MATE_UPPER || c == CHAR_MATE_LOWER) step = STEP_MATE;
         else if (is_digit(c)) begin
            whole_part = 16'(c - CHAR_DIGIT_0);
            step = STEP_WHOLE;
         end else step = STEP_MATE_END;
      endfunction

      function void take_token_byte(logic [7:0] c);
         int v;
         v = 0;
         case (step)
            STEP_START: begin
               if (c == CHAR_PLUS) step = STEP_SIGNED;
               else if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  step = STEP_SIGNED;
               end else read_lead(c);
            end
            STEP_SIGNED: read_lead(c);
            STEP_MATE: begin
               if (is_digit(c)) begin
                  v = int'(mate_count) * 10 + int'(c - CHAR_DIGIT_0);
                  mate_count = (v > int'(MATE_MAX)) ? MATE_MAX : v[13:0];
               end else step = STEP_MATE_END;
            end
            STEP_WHOLE: begin
               if (is_digit(c)) begin
                  v = int'(whole_part) * 10 + int'(c - CHAR_DIGIT_0);
                  whole_part = (v > int'(WHOLE_MAX)) ? WHOLE_MAX : v[15:0];
               end else if (c == CHAR_DOT) step = STEP_FRAC1;
               else step = STEP_NUM_END;
            end
            STEP_FRAC1: begin
               if (is_digit(c)) begin
                  fraction_part = 7'((c - CHAR_DIGIT_0) * 10);
                  step = STEP_FRAC2;
               end else step = STEP_NUM_END;
            end
            STEP_FRAC2: begin
               if (is_digit(c)) fraction_part = 7'(fraction_part + (c - CHAR_DIGIT_0));
               step = STEP_NUM_END;
            end
            default: ;
         endcase
         token_len++;
         phase = (token_len >= TOKEN_BUFFER_DEFAULT - 1) ? PHASE_DISCARD : PHASE_TOKEN;
      endfunction

      function void close_comment();
         rsp_item_type want;
         int total;
         want = '0;
         total = 0;
         if (step == STEP_MATE || step == STEP_MATE_END) begin
            if (mate_count != 0) begin
               total = int'(mate_base) - 2 * int'(mate_count) + 1;
               if (negative) total = -total;
               want.score_valid = 1'b1;
               mate_scores++;
            end
         end else if (step >= STEP_WHOLE) begin
            total = int'(whole_part) * 100 + int'(fraction_part);
            if (total > int'(SCORE_MAX)) total = int'(SCORE_MAX);
            if (negative) total = -total;
            want.score_valid = 1'b1;
         end
         want.score = total[15:0];
         if (want.score_valid) valid_scores++;
         closes++;
         expected_scores.push_back(want);
         clear_parse();
      endfunction

      function void note_input(req_item_type item);
         if (item.end_of_stream || item.ch == CHAR_CLOSE) close_comment();
         else if (phase == PHASE_SPACE) begin
            if (item.ch == CHAR_SLASH) phase = PHASE_DISCARD;
            else if (!is_space(item.ch)) take_token_byte(item.ch);
         end else if (phase == PHASE_TOKEN) begin
            if (is_space(item.ch) || item.ch == CHAR_SLASH) phase = PHASE_DISCARD;
            else take_token_byte(item.ch);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected score item: valid %0b score %0d",
                        $time, got.score_valid, got.score);
            return;
         end
         want = expected_scores.pop_front();
         if (got.score_valid !== want.score_valid || got.score !== want.score) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"[%0t] score mismatch: expected valid %0b score %0d, ",
                         "got valid %0b score %0d"},
                        $time, want.score_valid, want.score, got.score_valid, got.score);
         end
      endfunction

      function int pending();
         return expected_scores.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we = 1'b0;
   logic [14:0]  csr_wdata = '0;

   comment_scorer scorer = new();
   logic [7:0]    text[$];
   int            send_idle_pct = 20;
   int            recv_stall_pct = 87;
   int unsigned   bytes_sent = 0;
   int unsigned   settings_written = 0;

   comment_score_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) scorer.check_result(rsp_item);
         if (req_valid && req_ready) scorer.note_input(req_item);
      end
   end

   task automatic send_item(input logic [7:0] c, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{ch: c, end_of_stream: eos};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_comment(input bit by_eos, input logic [7:0] eos_ch);
      foreach (text[i]) send_item(text[i], 1'b0);
      if (by_eos) send_item(eos_ch, 1'b1);
      else send_item(CHAR_CLOSE, 1'b0);
      text.delete();
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scorer.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_checkmate(input logic [14:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      scorer.mate_base = value;
      settings_written++;
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_DIGIT_0 + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] random_space();
      case ($urandom_range(3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic void build_random_comment();
      int shape;
      int digits;
      shape = $urandom_range(99);
      repeat ($urandom_range(3)) text.push_back(random_space());
      if (shape < 12) begin
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
      end else begin
         case ($urandom_range(2))
            1: text.push_back(CHAR_PLUS);
            2: text.push_back(CHAR_MINUS);
            default: ;
         endcase
         digits = ($urandom_range(24) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 6);
         if (shape < 45) begin
            text.push_back($urandom_range(1) ? CHAR_MATE_UPPER : CHAR_MATE_LOWER);
            repeat (digits) text.push_back(random_digit());
         end else if (shape < 90) begin
            repeat ((digits == 0) ? 1 : digits) text.push_back(random_digit());
            if ($urandom_range(2) != 0) begin
               text.push_back(CHAR_DOT);
               repeat ($urandom_range(3)) text.push_back(random_digit());
            end
         end else begin
            text.push_back(8'($urandom));
            repeat ($urandom_range(2)) text.push_back(random_digit());
         end
         case ($urandom_range(3))
            1: text.push_back(random_space());
            2: text.push_back(CHAR_SLASH);
            default: ;
         endcase
         repeat ($urandom_range(4)) text.push_back(8'($urandom));
      end
   endfunction

   initial begin
      logic [14:0] mate_settings[6];
      int unsigned target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_comment(1'b0, 8'h00);
      push_text("+");
      send_comment(1'b1, CHAR_CLOSE);
      push_text("-x");
      send_comment(1'b0, 8'h00);
      push_text("M");
      send_comment(1'b0, 8'h00);
      push_text("m0");
      send_comment(1'b0, 8'h00);
      text.push_back(CHAR_SPACE);
      text.push_back(CHAR_TAB);
      text.push_back(CHAR_LF);
      text.push_back(CHAR_CR);
      push_text("-M3 zz");
      send_comment(1'b0, 8'h00);
      push_text("12.345");
      send_comment(1'b0, 8'h00);
      push_text("-0");
      send_comment(1'b0, 8'h00);
      push_text("99999999");
      send_comment(1'b0, 8'h00);
      push_text("+m99999");
      send_comment(1'b0, 8'h00);
      push_text("/5");
      send_comment(1'b0, 8'h00);
      push_text("7/3");
      send_comment(1'b0, 8'h00);
      push_text("1.x");
      send_comment(1'b0, 8'h00);
      text.push_back(8'h00);
      push_text("5");
      text.push_back(8'hFF);
      send_comment(1'b0, 8'h00);
      repeat (62) text.push_back(CHAR_DIGIT_0);
      push_text("57");
      send_comment(1'b0, 8'h00);
      push_text("-3.07");
      send_comment(1'b1, 8'hFF);

      mate_settings = '{15'd32767, 15'd1, 15'($urandom_range(2, 32766)), 15'd0,
                        15'($urandom_range(1, 32767)), CHECKMATE_RESET};
      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 20 : (seg < 4) ? 87 : 0;
         recv_stall_pct = (seg < 2) ? 87 : (seg < 4) ? 20 : 0;
         settle();
         write_checkmate(mate_settings[seg]);
         target = bytes_sent + BYTES_PER_SEGMENT;
         while (bytes_sent < target) begin
            build_random_comment();
            send_comment($urandom_range(9) == 0, 8'($urandom));
         end
      end
      settle();

      $display("Sent %0d comment bytes under %0d checkmate values and three idling patterns.",
               bytes_sent, settings_written + 1);
      $display("Checked %0d scores (%0d valid, %0d mates); %0d mismatches, %0d unanswered.",
               scorer.closes, scorer.valid_scores, scorer.mate_scores, scorer.mismatches,
               scorer.pending());
      if (scorer.mismatches == 0 && scorer.pending() == 0) begin
         $display("** comment_score_parser: PASSED **");
      end else begin
         $display("** comment_score_parser: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d scores still expected.", scorer.pending());
      $display("** comment_score_parser: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
rtl/csp_pkg.sv
rtl/csp_token.sv
rtl/csp_score.sv
rtl/comment_score_parser.sv
tb/sv/tb_comment_score_parser.sv
